// ===== sv/ddrp_pkg.sv =====
package ddrp_pkg;

  // Number of colour values in the last element of a record.
  localparam int NUM_COLOURS = 3;
  localparam int CIDX_W = $clog2(NUM_COLOURS + 1);
  // Colours that have an output port.
  localparam int PORT_COLOURS = 3;
  localparam int SHOWN_COLOURS = (NUM_COLOURS < PORT_COLOURS) ? NUM_COLOURS : PORT_COLOURS;

  localparam int VAL_W = 16;
  localparam int COL_W = 8;
  localparam int CHAR_W = 8;
  localparam int DIGIT_W = 4;
  localparam int PROD_W = VAL_W + 4;

  localparam logic [VAL_W-1:0] ACC_MAX = {VAL_W{1'b1}};
  localparam logic [COL_W-1:0] COLOUR_MAX = {COL_W{1'b1}};
  localparam logic [VAL_W-1:0] RATE_RESET = 16'd100;

  localparam logic [CHAR_W-1:0] CHAR_START = 8'h3A;  // ':'
  localparam logic [CHAR_W-1:0] CHAR_CLOSE = 8'h2E;  // '.'
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;  // ','
  localparam logic [CHAR_W-1:0] CHAR_END = 8'h3B;    // ';'
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;   // '0'
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;   // '9'

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_DIGIT,
    CLS_START,
    CLS_CLOSE,
    CLS_COMMA,
    CLS_END
  } char_class_e;

  typedef enum logic [2:0] {
    ELEM_UNIT,
    ELEM_PATTERN,
    ELEM_RATE,
    ELEM_COLOUR,
    ELEM_IDLE
  } element_e;

  typedef struct packed {
    char_class_e cls;
    logic [DIGIT_W-1:0] digit;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// ===== sv/ddrp_front.sv =====
module ddrp_front (
  input  logic                       in_valid_i,
  input  logic [ddrp_pkg::CHAR_W-1:0] char_in_i,
  input  ddrp_pkg::q_status_t        q_status_i,
  output logic                       in_stall_o,
  output logic                       push_o,
  output ddrp_pkg::cmd_t             cmd_o
);
  import ddrp_pkg::*;

  logic [CHAR_W-1:0] digit_off;

  assign digit_off = char_in_i - CHAR_ZERO;

  always_comb begin
    cmd_o.digit = digit_off[DIGIT_W-1:0];
    if (char_in_i >= CHAR_ZERO && char_in_i <= CHAR_NINE) begin
      cmd_o.cls = CLS_DIGIT;
    end else if (char_in_i == CHAR_START) begin
      cmd_o.cls = CLS_START;
    end else if (char_in_i == CHAR_CLOSE) begin
      cmd_o.cls = CLS_CLOSE;
    end else if (char_in_i == CHAR_COMMA) begin
      cmd_o.cls = CLS_COMMA;
    end else if (char_in_i == CHAR_END) begin
      cmd_o.cls = CLS_END;
    end else begin
      cmd_o.cls = CLS_NONE;
    end
  end

  // Characters with no meaning are accepted and dropped here.
  assign in_stall_o = q_status_i.full;
  assign push_o = in_valid_i && !q_status_i.full && (cmd_o.cls != CLS_NONE);

endmodule

// ===== sv/ddrp_queue.sv =====
module ddrp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ddrp_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output ddrp_pkg::q_status_t status_o,
  output ddrp_pkg::cmd_t      cmd_o
);
  import ddrp_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign status_o.valid = (count_q != '0);
  assign status_o.full = (count_q == QCNT_W'(QDEPTH));
  assign cmd_o = mem_q[rd_ptr_q];

endmodule

// ===== sv/ddrp_back.sv =====
module ddrp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  ddrp_pkg::cmd_t             cmd_i,
  output logic                       pop_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [ddrp_pkg::VAL_W-1:0] unit_select_o,
  output logic [ddrp_pkg::VAL_W-1:0] pattern_select_o,
  output logic [ddrp_pkg::VAL_W-1:0] rate_value_o,
  output logic [ddrp_pkg::COL_W-1:0] red_o,
  output logic [ddrp_pkg::COL_W-1:0] green_o,
  output logic [ddrp_pkg::COL_W-1:0] blue_o
);
  import ddrp_pkg::*;

  element_e          elem_q, elem_d;
  logic [CIDX_W-1:0] cidx_q, cidx_d;
  logic [VAL_W-1:0]  acc_q, acc_d;
  logic              prefix_q, prefix_d;
  logic [VAL_W-1:0]  unit_q, unit_d;
  logic [VAL_W-1:0]  pattern_q, pattern_d;
  logic [VAL_W-1:0]  rate_q, rate_d;
  logic [COL_W-1:0]  colour_q [NUM_COLOURS];
  logic [COL_W-1:0]  colour_d [NUM_COLOURS];

  logic              out_valid_q, out_valid_d;
  logic [VAL_W-1:0]  out_unit_q, out_pattern_q, out_rate_q;
  logic [COL_W-1:0]  out_colour_q [PORT_COLOURS];
  logic [COL_W-1:0]  shown_colour [PORT_COLOURS];

  logic              emit;
  logic              in_number;
  logic [PROD_W-1:0] prod;
  logic [COL_W-1:0]  clamped;
  logic              slot_left;

  assign in_number = (elem_q == ELEM_UNIT) || (elem_q == ELEM_PATTERN) ||
                     (elem_q == ELEM_RATE);
  // acc * 10 + digit, as two shifted copies.
  assign prod = (PROD_W'(acc_q) << 3) + (PROD_W'(acc_q) << 1) + PROD_W'(cmd_i.digit);
  assign clamped = (acc_q > VAL_W'(COLOUR_MAX)) ? COLOUR_MAX : acc_q[COL_W-1:0];
  assign slot_left = (cidx_q < CIDX_W'(NUM_COLOURS));

  // Handshake side: a record end waits only while the result register is blocked.
  always_comb begin
    pop_o = q_valid_i && ((cmd_i.cls != CLS_END) || !out_valid_q || !out_stall_i);
    emit = pop_o && (cmd_i.cls == CLS_END);
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_comb begin
    elem_d = elem_q;
    cidx_d = cidx_q;
    acc_d = acc_q;
    prefix_d = prefix_q;
    unit_d = unit_q;
    pattern_d = pattern_q;
    rate_d = rate_q;
    for (int k = 0; k < NUM_COLOURS; k++) begin
      colour_d[k] = colour_q[k];
    end
    if (pop_o) begin
      unique case (cmd_i.cls)
        CLS_START: begin
          elem_d = ELEM_UNIT;
          cidx_d = '0;
          acc_d = '0;
          prefix_d = 1'b0;
        end
        CLS_DIGIT: begin
          if ((in_number && !prefix_q) || (elem_q == ELEM_COLOUR && slot_left)) begin
            acc_d = (prod > PROD_W'(ACC_MAX)) ? ACC_MAX : prod[VAL_W-1:0];
          end
        end
        CLS_CLOSE, CLS_END: begin
          if (elem_q == ELEM_UNIT) begin
            unit_d = acc_q;
          end else if (elem_q == ELEM_PATTERN) begin
            pattern_d = acc_q;
          end else if (elem_q == ELEM_RATE) begin
            rate_d = acc_q;
          end
          if (cmd_i.cls == CLS_CLOSE && in_number) begin
            elem_d = element_e'(elem_q + 3'd1);
          end else begin
            elem_d = ELEM_IDLE;
          end
          // A period inside the colour list drops the pending colour.
          if (cmd_i.cls == CLS_END && elem_q == ELEM_COLOUR && slot_left) begin
            for (int k = 0; k < NUM_COLOURS; k++) begin
              if (cidx_q == CIDX_W'(k)) begin
                colour_d[k] = clamped;
              end
            end
            cidx_d = cidx_q + 1'b1;
          end
          acc_d = '0;
          prefix_d = 1'b0;
        end
        CLS_COMMA: begin
          if (in_number) begin
            prefix_d = 1'b1;
          end else if (elem_q == ELEM_COLOUR) begin
            if (slot_left) begin
              for (int k = 0; k < NUM_COLOURS; k++) begin
                if (cidx_q == CIDX_W'(k)) begin
                  colour_d[k] = clamped;
                end
              end
              cidx_d = cidx_q + 1'b1;
            end
            acc_d = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < PORT_COLOURS; k++) begin
      shown_colour[k] = '0;
    end
    for (int k = 0; k < SHOWN_COLOURS; k++) begin
      shown_colour[k] = colour_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= ELEM_UNIT;
      cidx_q <= '0;
      acc_q <= '0;
      prefix_q <= 1'b0;
      unit_q <= '0;
      pattern_q <= '0;
      rate_q <= RATE_RESET;
      for (int k = 0; k < NUM_COLOURS; k++) begin
        colour_q[k] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      elem_q <= elem_d;
      cidx_q <= cidx_d;
      acc_q <= acc_d;
      prefix_q <= prefix_d;
      unit_q <= unit_d;
      pattern_q <= pattern_d;
      rate_q <= rate_d;
      for (int k = 0; k < NUM_COLOURS; k++) begin
        colour_q[k] <= colour_d[k];
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_unit_q <= unit_d;
      out_pattern_q <= pattern_d;
      out_rate_q <= rate_d;
      for (int k = 0; k < PORT_COLOURS; k++) begin
        out_colour_q[k] <= shown_colour[k];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign unit_select_o = out_unit_q;
  assign pattern_select_o = out_pattern_q;
  assign rate_value_o = out_rate_q;
  assign red_o = out_colour_q[0];
  assign green_o = out_colour_q[1];
  assign blue_o = out_colour_q[2];

endmodule

// ===== sv/delimited_decimal_record_parser.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   char_in_i
// result    out        out_valid_o / out_stall_i unit_select_o, pattern_select_o,
//                                                rate_value_o, red_o, green_o, blue_o
//
// One character is accepted every cycle unless the queue is full; in the back end
// the multiply-by-ten accumulate sets the path length.
// A ';' request passes the queue and then the result register before its result shows.
// Reset clears the parser to the start of a record with rate 100 and all else zero.
// A two-entry queue sits between classification and execution; the input stalls
// only when it is full, which happens when a ';' waits on a blocked result register.
module delimited_decimal_record_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ddrp_pkg::CHAR_W-1:0] char_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ddrp_pkg::VAL_W-1:0] unit_select_o,
  output logic [ddrp_pkg::VAL_W-1:0] pattern_select_o,
  output logic [ddrp_pkg::VAL_W-1:0] rate_value_o,
  output logic [ddrp_pkg::COL_W-1:0] red_o,
  output logic [ddrp_pkg::COL_W-1:0] green_o,
  output logic [ddrp_pkg::COL_W-1:0] blue_o
);
  import ddrp_pkg::*;

  q_status_t q_status;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  logic      q_push;
  logic      q_pop;

  ddrp_front u_front (
    .in_valid_i (in_valid_i),
    .char_in_i  (char_in_i),
    .q_status_i (q_status),
    .in_stall_o (in_stall_o),
    .push_o     (q_push),
    .cmd_o      (push_cmd)
  );

  ddrp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .cmd_i    (push_cmd),
    .pop_i    (q_pop),
    .status_o (q_status),
    .cmd_o    (head_cmd)
  );

  ddrp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_status.valid),
    .cmd_i            (head_cmd),
    .pop_o            (q_pop),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .unit_select_o    (unit_select_o),
    .pattern_select_o (pattern_select_o),
    .rate_value_o     (rate_value_o),
    .red_o            (red_o),
    .green_o          (green_o),
    .blue_o           (blue_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("queue written while full");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_status.valid)
    else $error("queue read while empty");

  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_pop && (head_cmd.cls == CLS_END)))
    else $error("result raised without a record end");

endmodule

// ===== sim/tb.sv =====
module tb;
  import ddrp_pkg::*;

  localparam int TARGET_ITEMS = 1450;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [VAL_W-1:0] unit_sel;
    logic [VAL_W-1:0] pattern_sel;
    logic [VAL_W-1:0] rate_val;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } record_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    bit typed;
    record_t rec;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CHAR_W-1:0] char_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [VAL_W-1:0] unit_select_o;
  logic [VAL_W-1:0] pattern_select_o;
  logic [VAL_W-1:0] rate_value_o;
  logic [COL_W-1:0] red_o;
  logic [COL_W-1:0] green_o;
  logic [COL_W-1:0] blue_o;

  delimited_decimal_record_parser DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_in_i       (char_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .unit_select_o   (unit_select_o),
    .pattern_select_o(pattern_select_o),
    .rate_value_o    (rate_value_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o)
  );

  // Parser state as the predictor tracks it.
  element_e cur_elem;
  int colour_slot;
  logic [VAL_W-1:0] acc;
  bit after_comma;
  logic [VAL_W-1:0] held_unit;
  logic [VAL_W-1:0] held_pattern;
  logic [VAL_W-1:0] held_rate;
  logic [COL_W-1:0] held_colour [NUM_COLOURS];

  record_t pending_records[$];
  stim_row_t directed_rows[$];
  logic [CHAR_W-1:0] record_text[$];

  int errors = 0;
  int results_seen = 0;
  int items_counted = 0;
  int noise_sent = 0;
  int records_built = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int cycle_count = 0;
  int stall_run = 0;
  bit stall_hold = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void reset_parser();
    cur_elem = ELEM_UNIT;
    colour_slot = 0;
    acc = '0;
    after_comma = 1'b0;
    held_unit = '0;
    held_pattern = '0;
    held_rate = RATE_RESET;
    foreach (held_colour[k]) held_colour[k] = '0;
  endfunction

  function automatic void store_element();
    case (cur_elem)
      ELEM_UNIT: held_unit = acc;
      ELEM_PATTERN: held_pattern = acc;
      ELEM_RATE: held_rate = acc;
      default: ;
    endcase
  endfunction

  function automatic void commit_colour();
    if (colour_slot < NUM_COLOURS) begin
      held_colour[colour_slot] = (acc > VAL_W'(COLOUR_MAX)) ? COLOUR_MAX : acc[COL_W-1:0];
      colour_slot++;
    end
    acc = '0;
  endfunction

  function automatic logic [COL_W-1:0] shown_colour(input int k);
    return (k < NUM_COLOURS) ? held_colour[k] : '0;
  endfunction

  // Advances the parser by one character; returns 1 when a record is emitted.
  function automatic bit parse_char(input logic [CHAR_W-1:0] c, output record_t rec);
    logic [19:0] wide;
    bit take;
    rec = '0;
    take = 1'b0;
    if (c == CHAR_START) begin
      cur_elem = ELEM_UNIT;
      colour_slot = 0;
      acc = '0;
      after_comma = 1'b0;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      if (cur_elem < ELEM_COLOUR) begin
        take = !after_comma;
      end else if (cur_elem == ELEM_COLOUR) begin
        take = colour_slot < NUM_COLOURS;
      end
      if (take) begin
        wide = 20'(acc) * 20'd10 + 20'(c[3:0]);
        acc = (wide > 20'(ACC_MAX)) ? ACC_MAX : wide[VAL_W-1:0];
      end
    end else if (c == CHAR_CLOSE) begin
      if (cur_elem < ELEM_COLOUR) begin
        store_element();
        cur_elem = element_e'(cur_elem + 3'd1);
      end else begin
        cur_elem = ELEM_IDLE;
      end
      acc = '0;
      after_comma = 1'b0;
    end else if (c == CHAR_COMMA) begin
      if (cur_elem < ELEM_COLOUR) begin
        after_comma = 1'b1;
      end else if (cur_elem == ELEM_COLOUR) begin
        commit_colour();
      end
    end else if (c == CHAR_END) begin
      if (cur_elem < ELEM_COLOUR) begin
        store_element();
      end else if (cur_elem == ELEM_COLOUR) begin
        commit_colour();
      end
      cur_elem = ELEM_IDLE;
      acc = '0;
      after_comma = 1'b0;
      rec = '{held_unit, held_pattern, held_rate,
              shown_colour(0), shown_colour(1), shown_colour(2)};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_significant(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_START || c == CHAR_CLOSE ||
           c == CHAR_COMMA || c == CHAR_END;
  endfunction

  function automatic void add_row(input logic [CHAR_W-1:0] c, input bit typed,
                                  input record_t rec);
    stim_row_t row;
    row.ch = c;
    row.typed = typed;
    row.rec = rec;
    directed_rows.push_back(row);
  endfunction

  // Appends up to max_digits random digits, with an occasional stray byte.
  function automatic void add_number(input int max_digits);
    int n;
    n = $urandom_range(0, max_digits);
    for (int k = 0; k < n; k++) begin
      record_text.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 24) == 0) record_text.push_back(8'h80 | CHAR_W'($urandom));
    end
  endfunction

  function automatic void build_record();
    int kind;
    int parts;
    int slots;
    record_text.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 92) begin
      repeat ($urandom_range(1, 8)) record_text.push_back(CHAR_W'($urandom_range(0, 255)));
      return;
    end
    if (kind >= 86) begin
      // Text with no start mark; after an end mark only its own end mark, if any, emits a result.
      add_number(4);
      record_text.push_back(CHAR_COMMA);
      add_number(3);
      if ($urandom_range(0, 1) == 0) record_text.push_back(CHAR_END);
      return;
    end
    record_text.push_back(CHAR_START);
    parts = (kind < 70) ? 3 : $urandom_range(0, 3);
    for (int k = 0; k < parts; k++) begin
      add_number(6);
      if ($urandom_range(0, 5) == 0) begin
        record_text.push_back(CHAR_COMMA);
        add_number(3);
      end
      record_text.push_back(CHAR_CLOSE);
    end
    if (parts == 3) begin
      slots = (kind < 70) ? NUM_COLOURS : $urandom_range(0, NUM_COLOURS + 2);
      for (int k = 0; k < slots; k++) begin
        add_number(4);
        if (k < slots - 1) record_text.push_back(CHAR_COMMA);
      end
      if (kind >= 76 && kind < 80) begin
        add_number(3);
        record_text.push_back(CHAR_CLOSE);
      end
    end else begin
      add_number(6);
    end
    if (kind < 70 || $urandom_range(0, 3) != 0) record_text.push_back(CHAR_END);
    if ($urandom_range(0, 9) == 0) record_text.push_back(CHAR_END);
  endfunction

  // Presents one request, in bursts with random gaps while gaps_on is set, and predicts on acceptance.
  task automatic send_char(input logic [CHAR_W-1:0] c, input bit use_typed,
                           input record_t typed);
    record_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    char_in_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (is_significant(c)) items_counted++;
    else noise_sent++;
    if (parse_char(c, predicted)) pending_records.push_back(use_typed ? typed : predicted);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_records.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    record_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d %0d %0d",
                 $time, unit_select_o, pattern_select_o, rate_value_o, red_o, green_o,
                 blue_o);
        errors++;
      end else begin
        want = pending_records.pop_front();
        check_field("unit_select", want.unit_sel, unit_select_o);
        check_field("pattern_select", want.pattern_sel, pattern_select_o);
        check_field("rate_value", want.rate_val, rate_value_o);
        check_field("red", want.red, red_o);
        check_field("green", want.green, green_o);
        check_field("blue", want.blue, blue_o);
        results_seen++;
      end
    end
  end

  // Result side: runs of stall and no stall, with quiet stretches every so often.
  always @(posedge clk_i) begin
    cycle_count++;
    if (stall_run == 0) begin
      stall_hold = ($urandom_range(0, 2) == 0);
      stall_run = $urandom_range(1, 10);
    end
    stall_run--;
    out_stall_i <= stall_hold && (cycle_count[9:8] != 2'b00);
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("tb failed");
    $finish;
  end

  initial begin : stimulus
    record_t rec_reset;
    record_t rec_extreme;
    reset_parser();
    rec_reset = '{16'd0, 16'd0, RATE_RESET, 8'd0, 8'd0, 8'd0};
    rec_extreme = '{ACC_MAX, 16'd0, 16'd1, COLOUR_MAX, COLOUR_MAX, 8'd0};

    // End mark straight after reset, then one record that saturates the first
    // element, leaves the second empty, drops digits after a comma in the third,
    // clamps the first colour, skips a stray byte and leaves the last colour empty.
    add_row(CHAR_END, 1'b1, rec_reset);
    add_row(CHAR_START, 1'b0, '0);
    add_row("7", 1'b0, '0);
    add_row("0", 1'b0, '0);
    add_row("0", 1'b0, '0);
    add_row("0", 1'b0, '0);
    add_row("0", 1'b0, '0);
    add_row(CHAR_CLOSE, 1'b0, '0);
    add_row(CHAR_CLOSE, 1'b0, '0);
    add_row("1", 1'b0, '0);
    add_row(CHAR_COMMA, 1'b0, '0);
    add_row("5", 1'b0, '0);
    add_row(CHAR_CLOSE, 1'b0, '0);
    add_row("3", 1'b0, '0);
    add_row("0", 1'b0, '0);
    add_row("0", 1'b0, '0);
    add_row(CHAR_COMMA, 1'b0, '0);
    add_row("2", 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    add_row("5", 1'b0, '0);
    add_row("5", 1'b0, '0);
    add_row(CHAR_COMMA, 1'b0, '0);
    add_row(CHAR_COMMA, 1'b0, '0);
    add_row(CHAR_END, 1'b1, rec_extreme);
    add_row(CHAR_END, 1'b1, rec_extreme);
    add_row(8'h00, 1'b0, '0);

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_char(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].rec);
    end
    drain_results();

    while (items_counted < TARGET_ITEMS) begin
      build_record();
      records_built++;
      gaps_on = ($urandom_range(0, 3) != 0);
      foreach (record_text[i]) send_char(record_text[i], 1'b0, '0);
      if ($urandom_range(0, 39) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d parsed characters and %0d stray bytes over %0d random sequences.",
             items_counted, noise_sent, records_built);
    $display("Compared %0d records, %0d field mismatches or stray results.",
             results_seen, errors);
    if (errors == 0 && pending_records.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
